>>> hdl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; imported by utf8_to_ucs2_decoder_core and tb_top.
package utf8d_pkg;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [15:0] BAD_WORD  = 16'hFFFF;
    localparam logic [15:0] TERM_WORD = 16'h0000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        terminator;
        logic [15:0] word_count;
        logic        run_last;
    } t_result;

endpackage

>>> hdl/utf8_to_ucs2_decoder_core.sv
// UTF-8 to UCS-2 decoder core: byte decode state and a four-word result queue.
// Depends on utf8d_pkg (result type, queue sizing, fixed code words).
//
// The block takes one source byte per cycle while o_ready is high. The byte
// flagged as first opens a string and samples the byte count and destination
// capacity; a string that ends closes with a zero word carrying the word count.
// All decoding for a byte completes in the cycle it is accepted, and its zero,
// one or two result words enter a four-entry queue; the output side delivers one
// word per cycle while i_ready is high. The input is ready while the queue holds
// two words or fewer, so one byte per cycle holds whenever the consumer takes
// words as they come; a closing step may leave two words and drop o_ready.
module utf8_to_ucs2_decoder_core #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  logic [15:0] i_src_length,
    input  logic [15:0] i_dst_capacity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_terminator,
    output logic [15:0] o_word_count,
    output logic        o_run_last
);
    import utf8d_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int PB = LENGTH_BITS + 3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_CONT = 2'd2;
    localparam logic [1:0] PH_SKIP = 2'd3;

    logic [1:0]    r_phase,    n_phase;
    logic [LB-1:0] r_pos,      n_pos;
    logic [2:0]    r_pending,  n_pending;
    logic [15:0]   r_partial,  n_partial;
    logic [LB-1:0] r_words,    n_words;
    logic [LB-1:0] r_length,   n_length;
    logic [LB-1:0] r_capacity, n_capacity;

    t_result             r_q [QDEPTH];
    logic [QIDX_W-1:0]   r_rd_ptr, r_wr_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic              accept, pop, run, finish, bad_lead, word_emit, term_emit;
    logic [1:0]        nres;
    logic [LB+15:0]    len_ext, cap_ext;
    logic [LB-1:0]     len_in, cap_in, cur_pos;
    logic [PB-1:0]     cur_pos_ext, fin_next, len_cmp;
    logic [15:0]       word_val;
    t_result           res0, res1;

    function automatic t_result f_result(input logic [15:0] code, input logic term,
                                         input logic [LB-1:0] words);
        logic [LB+15:0] ext;
        t_result        r;
        ext          = {16'b0, words};
        r.code_unit  = code;
        r.terminator = term;
        r.word_count = ext[15:0];
        r.run_last   = 1'b0;
        return r;
    endfunction

    assign accept  = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_ready = (r_count <= QCNT_W'(QDEPTH - 2));

    assign len_ext = {{LB{1'b0}}, i_src_length};
    assign cap_ext = {{LB{1'b0}}, i_dst_capacity};
    assign len_in  = len_ext[LB-1:0];
    assign cap_in  = cap_ext[LB-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_words     = r_words;
        n_length    = r_length;
        n_capacity  = r_capacity;
        run         = 1'b0;
        finish      = 1'b0;
        bad_lead    = 1'b0;
        word_emit   = 1'b0;
        term_emit   = 1'b0;
        word_val    = r_partial;
        cur_pos     = r_pos;
        cur_pos_ext = '0;
        fin_next    = '0;
        len_cmp     = '0;
        if (accept) begin
            if (i_first) begin
                n_length   = len_in;
                n_capacity = cap_in;
                n_pos      = '0;
                n_pending  = 3'd0;
                n_partial  = 16'd0;
                n_words    = '0;
                if (len_in == '0 || cap_in <= LB'(1) || i_data_byte == 8'd0) begin
                    term_emit = 1'b1;
                    n_phase   = PH_IDLE;
                end else begin
                    n_phase = PH_LEAD;
                    run     = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                run = 1'b1;
            end
        end
        if (run) begin
            cur_pos     = n_pos;
            cur_pos_ext = {3'b0, cur_pos};
            len_cmp     = {3'b0, n_length};
            n_pos       = cur_pos + LB'(1);
            case (n_phase)
                PH_LEAD: begin
                    if (i_data_byte == 8'd0) begin
                        term_emit = 1'b1;
                        n_phase   = PH_IDLE;
                    end else if (!i_data_byte[7]) begin
                        word_val = {8'b0, i_data_byte};
                        finish   = 1'b1;
                        fin_next = cur_pos_ext + PB'(1);
                    end else if (i_data_byte[7:5] == 3'b110) begin
                        if (cur_pos_ext + PB'(2) > len_cmp) begin
                            term_emit = 1'b1;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_partial = {4'b0, i_data_byte[5:0], 6'b0};
                            n_pending = 3'd1;
                            n_phase   = PH_CONT;
                        end
                    end else if (i_data_byte[7:4] == 4'b1110) begin
                        if (cur_pos_ext + PB'(3) > len_cmp) begin
                            term_emit = 1'b1;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_partial = {i_data_byte[3:0], 12'b0};
                            n_pending = 3'd2;
                            n_phase   = PH_CONT;
                        end
                    end else begin
                        word_val = BAD_WORD;
                        bad_lead = 1'b1;
                        finish   = 1'b1;
                        fin_next = cur_pos_ext + PB'(5);
                    end
                end
                PH_CONT: begin
                    if (n_pending >= 3'd2) begin
                        n_partial = n_partial | {4'b0, i_data_byte[5:0], 6'b0};
                        n_pending = 3'd1;
                    end else begin
                        word_val  = n_partial | {10'b0, i_data_byte[5:0]};
                        n_partial = word_val;
                        n_pending = 3'd0;
                        finish    = 1'b1;
                        fin_next  = cur_pos_ext + PB'(1);
                    end
                end
                PH_SKIP: begin
                    if (n_pending != 3'd0) begin
                        n_pending = n_pending - 3'd1;
                    end
                    if (n_pending == 3'd0) begin
                        n_phase = PH_LEAD;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            if (finish) begin
                word_emit = 1'b1;
                n_partial = word_val;
                n_words   = n_words + LB'(1);
                if (fin_next >= len_cmp
                    || {1'b0, n_capacity} == {1'b0, n_words} + (LB+1)'(1)) begin
                    term_emit = 1'b1;
                    n_phase   = PH_IDLE;
                end else if (bad_lead) begin
                    n_phase   = PH_SKIP;
                    n_pending = 3'd4;
                end else begin
                    n_phase = PH_LEAD;
                end
            end
        end
    end

    always_comb begin
        res0 = f_result(word_val, 1'b0, n_words);
        res1 = f_result(TERM_WORD, 1'b1, n_words);
        nres = 2'd0;
        if (word_emit && term_emit) begin
            res1.run_last = 1'b1;
            nres          = 2'd2;
        end else if (word_emit) begin
            res0.run_last = 1'b1;
            nres          = 2'd1;
        end else if (term_emit) begin
            res0          = res1;
            res0.run_last = 1'b1;
            nres          = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_pending  <= 3'd0;
            r_partial  <= 16'd0;
            r_words    <= '0;
            r_length   <= '0;
            r_capacity <= '0;
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_count    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_pending  <= n_pending;
            r_partial  <= n_partial;
            r_words    <= n_words;
            r_length   <= n_length;
            r_capacity <= n_capacity;
            r_rd_ptr   <= r_rd_ptr + QIDX_W'(pop);
            r_wr_ptr   <= r_wr_ptr + QIDX_W'(nres);
            r_count    <= r_count + QCNT_W'(nres) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (nres != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (nres == 2'd2) begin
            r_q[r_wr_ptr + QIDX_W'(1)] <= res1;
        end
    end

    assign o_code_unit  = r_q[r_rd_ptr].code_unit;
    assign o_terminator = r_q[r_rd_ptr].terminator;
    assign o_word_count = r_q[r_rd_ptr].word_count;
    assign o_run_last   = r_q[r_rd_ptr].run_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_no_work_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_first && r_phase == PH_IDLE |-> nres == 2'd0)
        else $error("result from a byte outside any string");

    a_term_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_terminator |-> o_run_last && o_code_unit == TERM_WORD)
        else $error("terminator word malformed");

    a_term_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && term_emit |=> r_phase == PH_IDLE)
        else $error("decoder still active after terminator");

    a_first_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_first |=> r_words <= LB'(1))
        else $error("word count not restarted on first byte");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for utf8_to_ucs2_decoder_core: byte strings in, UCS-2 words out.
// Depends on utf8d_pkg (result type, fixed code words) and the decoder core RTL.
// A clocked driver and monitor exercise the valid/ready channels; an in-bench decoder predicts.
`timescale 1ns / 100ps

module tb_top;

    import utf8d_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          STALL_AT       = 200;
    localparam int          STALL_CYCLES   = 120;
    localparam int          PHASE_BYTES    = 290;
    localparam logic [7:0]  TOP_BIT        = 8'h80;
    localparam logic [7:0]  LEAD3_MASK     = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE     = 8'hC0;
    localparam logic [7:0]  LEAD4_MASK     = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE     = 8'hE0;
    localparam logic [7:0]  CONT_BITS      = 8'h3F;
    localparam int          BAD_SPAN       = 5;
    localparam int          BAD_SKIP       = 4;

    typedef enum logic [1:0] {DEC_IDLE, DEC_LEAD, DEC_CONT, DEC_SKIP} t_dec_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic [15:0] src_length;
        logic [15:0] dst_capacity;
    } t_src_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_first = 1'b0;
    logic [15:0] i_src_length = 16'h0000;
    logic [15:0] i_dst_capacity = 16'h0000;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_terminator;
    logic [15:0] o_word_count;
    logic        o_run_last;

    t_src_byte   byte_q[$];
    t_src_byte   held_item;
    t_result     word_exp_q[$];
    t_result     step_res[0:1];
    int          step_n;

    t_dec_phase  dec_phase = DEC_IDLE;
    int unsigned dec_pos = 0;
    int unsigned dec_pending = 0;
    logic [15:0] dec_partial = 16'h0000;
    int unsigned dec_written = 0;
    int unsigned len_held = 0;
    int unsigned cap_held = 0;

    int          send_idle_pct = 13;
    int          recv_idle_pct = 47;
    int          bytes_taken = 0;
    int          mismatches = 0;
    int          stall_left = 0;
    logic        stall_done = 1'b0;
    int          quiet_cycles = 0;

    utf8_to_ucs2_decoder_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_first        (i_first),
        .i_src_length   (i_src_length),
        .i_dst_capacity (i_dst_capacity),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_unit    (o_code_unit),
        .o_terminator   (o_terminator),
        .o_word_count   (o_word_count),
        .o_run_last     (o_run_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_word(input logic [15:0] code, input logic term);
        step_res[step_n] = '{code_unit: code, terminator: term,
                             word_count: dec_written[15:0], run_last: 1'b0};
        step_n++;
    endfunction

    function automatic void close_word(input int unsigned next_pos);
        dec_written++;
        push_word(dec_partial, 1'b0);
        if (next_pos >= len_held || cap_held == dec_written + 1) begin
            push_word(TERM_WORD, 1'b1);
            dec_phase = DEC_IDLE;
        end else begin
            dec_phase = DEC_LEAD;
        end
    endfunction

    function automatic void decode_byte(input t_src_byte b);
        int unsigned here;
        step_n = 0;
        if (b.first) begin
            len_held    = b.src_length;
            cap_held    = b.dst_capacity;
            dec_pos     = 0;
            dec_pending = 0;
            dec_partial = 16'h0000;
            dec_written = 0;
            if (len_held == 0 || cap_held <= 1 || b.data_byte == 8'h00) begin
                dec_phase = DEC_IDLE;
                push_word(TERM_WORD, 1'b1);
            end else begin
                dec_phase = DEC_LEAD;
            end
        end
        if (dec_phase != DEC_IDLE) begin
            here    = dec_pos;
            dec_pos = here + 1;
            case (dec_phase)
                DEC_LEAD: begin
                    if (b.data_byte == 8'h00) begin
                        push_word(TERM_WORD, 1'b1);
                        dec_phase = DEC_IDLE;
                    end else if ((b.data_byte & TOP_BIT) == 8'h00) begin
                        dec_partial = {8'h00, b.data_byte};
                        close_word(here + 1);
                    end else if ((b.data_byte & LEAD3_MASK) == LEAD2_CODE) begin
                        if (here + 2 > len_held) begin
                            push_word(TERM_WORD, 1'b1);
                            dec_phase = DEC_IDLE;
                        end else begin
                            dec_partial = {4'h0, b.data_byte[5:0], 6'h00};
                            dec_pending = 1;
                            dec_phase   = DEC_CONT;
                        end
                    end else if ((b.data_byte & LEAD4_MASK) == LEAD3_CODE) begin
                        if (here + 3 > len_held) begin
                            push_word(TERM_WORD, 1'b1);
                            dec_phase = DEC_IDLE;
                        end else begin
                            dec_partial = {b.data_byte[3:0], 12'h000};
                            dec_pending = 2;
                            dec_phase   = DEC_CONT;
                        end
                    end else begin
                        dec_partial = BAD_WORD;
                        close_word(here + BAD_SPAN);
                        if (dec_phase != DEC_IDLE) begin
                            dec_phase   = DEC_SKIP;
                            dec_pending = BAD_SKIP;
                        end
                    end
                end
                DEC_CONT: begin
                    if (dec_pending >= 2) begin
                        dec_partial = dec_partial | {4'h0, b.data_byte[5:0], 6'h00};
                        dec_pending = 1;
                    end else begin
                        dec_partial = dec_partial | {8'h00, b.data_byte & CONT_BITS};
                        dec_pending = 0;
                        close_word(dec_pos);
                    end
                end
                DEC_SKIP: begin
                    if (dec_pending > 0) dec_pending--;
                    if (dec_pending == 0) dec_phase = DEC_LEAD;
                end
                default: begin
                    dec_phase = DEC_IDLE;
                end
            endcase
        end
        for (int k = 0; k < step_n; k++) begin
            if (k == step_n - 1) step_res[k].run_last = 1'b1;
            word_exp_q.push_back(step_res[k]);
        end
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        mismatches++;
        $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
    endtask

    task automatic check_word();
        t_result want;
        if (word_exp_q.size() == 0) begin
            flag_mismatch("unexpected word", o_code_unit, 16'h0000);
        end else begin
            want = word_exp_q.pop_front();
            if (o_code_unit !== want.code_unit)
                flag_mismatch("code_unit", o_code_unit, want.code_unit);
            if (o_terminator !== want.terminator)
                flag_mismatch("terminator", {15'h0, o_terminator}, {15'h0, want.terminator});
            if (o_word_count !== want.word_count)
                flag_mismatch("word_count", o_word_count, want.word_count);
            if (o_run_last !== want.run_last)
                flag_mismatch("run_last", {15'h0, o_run_last}, {15'h0, want.run_last});
        end
    endtask

    function automatic void push_byte(input logic [7:0] data, input logic first,
                                      input logic [15:0] len, input logic [15:0] cap);
        byte_q.push_back('{data_byte: data, first: first, src_length: len, dst_capacity: cap});
    endfunction

    function automatic int queue_string();
        logic [7:0]  body[$];
        int          units;
        int          pick;
        int          sent;
        logic [15:0] len;
        logic [15:0] cap;
        units = $urandom_range(1, 8);
        for (int u = 0; u < units; u++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                body.push_back(8'($urandom_range(1, 127)));
            end else if (pick < 55) begin
                body.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                body.push_back(8'($urandom));
            end else if (pick < 73) begin
                body.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
            end else if (pick < 86) begin
                if ($urandom_range(1) == 0)
                    body.push_back(8'($urandom_range(8'h80, 8'hBF)));
                else
                    body.push_back(8'($urandom_range(8'hF0, 8'hFF)));
                repeat (BAD_SKIP) body.push_back(8'($urandom));
            end else if (pick < 91) begin
                body.push_back(8'h00);
            end else begin
                body.push_back(8'($urandom));
            end
        end
        pick = $urandom_range(99);
        if (pick < 65)      len = 16'(body.size());
        else if (pick < 80) len = 16'($urandom_range(1, body.size()));
        else if (pick < 88) len = 16'(body.size() + $urandom_range(1, 3));
        else if (pick < 96) len = 16'($urandom_range(65535));
        else                len = 16'h0000;
        pick = $urandom_range(99);
        if (pick < 50)      cap = 16'($urandom_range(2, 12));
        else if (pick < 70) cap = 16'hFFFF;
        else if (pick < 80) cap = 16'($urandom_range(0, 1));
        else                cap = 16'($urandom_range(65535));
        sent = body.size();
        if ($urandom_range(9) == 0) sent = $urandom_range(1, body.size());
        for (int k = 0; k < sent; k++)
            push_byte(body[k], k == 0, k == 0 ? len : 16'($urandom),
                      k == 0 ? cap : 16'($urandom));
        if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 3))
                push_byte(8'($urandom), 1'b0, 16'($urandom), 16'($urandom));
        return sent;
    endfunction

    task automatic drain_all();
        while (byte_q.size() != 0 || i_valid || word_exp_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_strings(input int quota);
        int sent;
        sent = 0;
        while (sent < quota) sent += queue_string();
        drain_all();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_byte(8'h41, 1'b1, 16'd0, 16'd10);
        push_byte(8'h41, 1'b1, 16'd5, 16'd1);
        push_byte(8'h41, 1'b1, 16'd5, 16'd0);
        push_byte(8'h00, 1'b1, 16'd5, 16'd10);
        push_byte(8'h7F, 1'b1, 16'd1, 16'hFFFF);
        push_byte(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF);
        push_byte(8'hC3, 1'b1, 16'd2, 16'd8);
        push_byte(8'hA9, 1'b0, 16'd0, 16'd0);
        push_byte(8'hE2, 1'b1, 16'd3, 16'd8);
        push_byte(8'h82, 1'b0, 16'd0, 16'd0);
        push_byte(8'hAC, 1'b0, 16'd0, 16'd0);
        push_byte(8'h61, 1'b1, 16'd5, 16'd2);
        push_byte(8'h62, 1'b0, 16'd0, 16'd0);
        push_byte(8'h78, 1'b1, 16'd4, 16'd10);
        push_byte(8'h00, 1'b0, 16'd0, 16'd0);
        push_byte(8'hC3, 1'b1, 16'd1, 16'd8);
        push_byte(8'hE2, 1'b1, 16'd2, 16'd8);
        push_byte(8'h82, 1'b0, 16'd0, 16'd0);
        push_byte(8'hF0, 1'b1, 16'd6, 16'd10);
        push_byte(8'h11, 1'b0, 16'd0, 16'd0);
        push_byte(8'h22, 1'b0, 16'd0, 16'd0);
        push_byte(8'h33, 1'b0, 16'd0, 16'd0);
        push_byte(8'h44, 1'b0, 16'd0, 16'd0);
        push_byte(8'h7A, 1'b0, 16'd0, 16'd0);
        push_byte(8'h80, 1'b1, 16'd3, 16'd10);
        push_byte(8'h71, 1'b1, 16'd9, 16'd10);
        push_byte(8'h72, 1'b1, 16'd1, 16'd10);
        drain_all();

        run_strings(PHASE_BYTES);
        send_idle_pct = 47;
        recv_idle_pct = 13;
        run_strings(PHASE_BYTES);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_strings(PHASE_BYTES);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (word_exp_q.size() != 0) begin
            flag_mismatch("missing word", 16'h0000, word_exp_q[0].code_unit);
            void'(word_exp_q.pop_front());
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // driver: hold the byte until taken, then optionally idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                decode_byte(held_item);
                bytes_taken++;
            end
            if (!i_valid || o_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_item = byte_q.pop_front();
                    i_valid        <= 1'b1;
                    i_data_byte    <= held_item.data_byte;
                    i_first        <= held_item.first;
                    i_src_length   <= held_item.src_length;
                    i_dst_capacity <= held_item.dst_capacity;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each word taken, hold ready low through the long stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) check_word();
            if (!stall_done && bytes_taken >= STALL_AT) begin
                stall_left = STALL_CYCLES;
                stall_done = 1'b1;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule

>>> utf8_to_ucs2_decoder_core.f
hdl/utf8d_pkg.sv
hdl/utf8_to_ucs2_decoder_core.sv
sim/tb_top.sv
